// ===== rtl/qau_pkg.sv =====
// Quaternion arithmetic unit: shared operation codes and the Hamilton sign table.
// No dependencies; imported by every module of the unit.
package qau_pkg;

    localparam int FUNC_BITS = 3;

    localparam logic [FUNC_BITS-1:0] FUNC_PROD  = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_ADD   = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_SUB   = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_SCALE = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_NORM  = 3'd4;

    // Bit r*4+j set: term a[j]*b[r^j] of result row r is subtracted.
    localparam logic [15:0] HAM_NEG = 16'h428E;

endpackage

// ===== rtl/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit: Hamilton product, add, subtract, scale, normalize.
// Throughput one word per cycle while the skid register is empty; the whole pipeline stalls
// while it holds a word. Fully pipelined through the square-root digit stages (WORD_BITS+1)
// and the divider setup and quotient stages (FRAC_BITS+2); a skid register at the output.
// Reset clears all valid bits, including output and skid valid; datapath registers are not reset.
// Depends on qau_pkg, qau_front, qau_sqrt, qau_div.
module quaternion_arithmetic_unit
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = 20,
    parameter int WORD_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [FUNC_BITS-1:0]        func,
    input  logic signed [WORD_BITS-1:0] a_w,
    input  logic signed [WORD_BITS-1:0] a_x,
    input  logic signed [WORD_BITS-1:0] a_y,
    input  logic signed [WORD_BITS-1:0] a_z,
    input  logic signed [WORD_BITS-1:0] b_w,
    input  logic signed [WORD_BITS-1:0] b_x,
    input  logic signed [WORD_BITS-1:0] b_y,
    input  logic signed [WORD_BITS-1:0] b_z,
    input  logic signed [WORD_BITS-1:0] scale_factor,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [WORD_BITS-1:0] r_w,
    output logic signed [WORD_BITS-1:0] r_x,
    output logic signed [WORD_BITS-1:0] r_y,
    output logic signed [WORD_BITS-1:0] r_z,
    output logic                        saturated,
    output logic                        zero_magnitude
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int N   = W + 1;
    localparam int SQW = 8 * W + 7;
    localparam int DVW = 4 * W + 7;
    localparam int CW  = ((F + 2 > W + 1) ? F + 2 : W + 1) + 1;

    localparam logic signed [CW-1:0] MAXV = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {{(CW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic en;
    logic out_valid_reg;
    logic skid_valid_reg;

    // whole pipeline moves unless the skid register holds a word
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // ---------------- front end
    logic              fe_valid;
    logic [3:0][W-1:0] fe_res;
    logic              fe_sat;
    logic              fe_norm;
    logic              fe_zero;
    logic [2*N-1:0]    fe_ssum;
    logic [3:0][W-1:0] fe_absa;
    logic [3:0]        fe_nega;

    qau_front #(
        .W (W),
        .F (F)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .func      (func),
        .a         ({a_z, a_y, a_x, a_w}),
        .b         ({b_z, b_y, b_x, b_w}),
        .k         (scale_factor),
        .out_valid (fe_valid),
        .res       (fe_res),
        .res_sat   (fe_sat),
        .is_norm   (fe_norm),
        .all_zero  (fe_zero),
        .ssum      (fe_ssum),
        .absa      (fe_absa),
        .nega      (fe_nega)
    );

    // ---------------- magnitude
    logic           sq_valid;
    logic [N-1:0]   sq_root;
    logic [SQW-1:0] sq_side;

    qau_sqrt #(
        .N      (N),
        .SIDE_W (SQW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fe_valid),
        .radicand  (fe_ssum),
        .side_in   ({fe_absa, fe_res, fe_sat, fe_norm, fe_zero, fe_nega}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // ---------------- divide
    logic              dv_valid;
    logic [3:0][F:0]   dv_quot;
    logic [DVW-1:0]    dv_side;
    logic [3:0][W-1:0] dv_res;
    logic              dv_sat;
    logic              dv_norm;
    logic              dv_zero;
    logic [3:0]        dv_nega;

    qau_div #(
        .W      (W),
        .F      (F),
        .SIDE_W (DVW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .mag       (sq_root),
        .absa      (sq_side[SQW-1 -: 4*W]),
        .side_in   (sq_side[DVW-1:0]),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .side_out  (dv_side)
    );

    assign {dv_res, dv_sat, dv_norm, dv_zero, dv_nega} = dv_side;

    // ---------------- final stage: sign, clip, select
    logic signed [CW-1:0] nv [4];
    logic [3:0][W-1:0]    fin_r_next;
    logic                 fin_sat_next;
    logic                 fin_zm_next;

    always_comb
    begin
        fin_r_next   = dv_res;
        fin_sat_next = dv_sat;
        fin_zm_next  = 1'b0;
        for (int l = 0; l < 4; l++)
        begin
            nv[l] = CW'($signed({1'b0, dv_quot[l]}));
            if (dv_nega[l])
            begin
                nv[l] = -nv[l];
            end
        end
        if (dv_norm)
        begin
            fin_sat_next = 1'b0;
            if (dv_zero)
            begin
                fin_r_next  = '0;
                fin_zm_next = 1'b1;
            end
            else
            begin
                for (int l = 0; l < 4; l++)
                begin
                    if (nv[l] > MAXV)
                    begin
                        fin_r_next[l] = MAXV[W-1:0];
                        fin_sat_next  = 1'b1;
                    end
                    else if (nv[l] < MINV)
                    begin
                        fin_r_next[l] = MINV[W-1:0];
                        fin_sat_next  = 1'b1;
                    end
                    else
                    begin
                        fin_r_next[l] = nv[l][W-1:0];
                    end
                end
            end
        end
    end

    logic              fin_valid_reg;
    logic [3:0][W-1:0] fin_r_reg;
    logic              fin_sat_reg;
    logic              fin_zm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_r_reg   <= fin_r_next;
            fin_sat_reg <= fin_sat_next;
            fin_zm_reg  <= fin_zm_next;
        end
    end

    // ---------------- output register and skid
    logic              out_valid_next;
    logic              skid_valid_next;
    logic              load_out_fin;
    logic              load_out_skid;
    logic              load_skid;
    logic [3:0][W-1:0] out_r_reg;
    logic              out_sat_reg;
    logic              out_zm_reg;
    logic [3:0][W-1:0] skid_r_reg;
    logic              skid_sat_reg;
    logic              skid_zm_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_fin    = 1'b0;
        load_out_skid   = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                load_out_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (fin_valid_reg)
        begin
            if (!out_valid_reg || out_ready)
            begin
                load_out_fin   = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_fin)
        begin
            out_r_reg   <= fin_r_reg;
            out_sat_reg <= fin_sat_reg;
            out_zm_reg  <= fin_zm_reg;
        end
        else if (load_out_skid)
        begin
            out_r_reg   <= skid_r_reg;
            out_sat_reg <= skid_sat_reg;
            out_zm_reg  <= skid_zm_reg;
        end
        if (load_skid)
        begin
            skid_r_reg   <= fin_r_reg;
            skid_sat_reg <= fin_sat_reg;
            skid_zm_reg  <= fin_zm_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign r_w            = out_r_reg[0];
    assign r_x            = out_r_reg[1];
    assign r_y            = out_r_reg[2];
    assign r_z            = out_r_reg[3];
    assign saturated      = out_sat_reg;
    assign zero_magnitude = out_zm_reg;

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without an output stall");

    a_zero_mag_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && zero_magnitude |->
            r_w == '0 && r_x == '0 && r_y == '0 && r_z == '0 && !saturated)
        else $error("zero-length normalize word not all zero");

    a_no_loss_on_skid: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_ready |=> skid_valid_reg)
        else $error("skid word dropped during stall");
`endif

endmodule

// ===== rtl/qau_front.sv =====
// Front end of the quaternion unit: multipliers, row sums, rounding and clipping.
// Three register stages. Depends on qau_pkg.
module qau_front
    import qau_pkg::*;
#(
    parameter int W = 24,
    parameter int F = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [FUNC_BITS-1:0] func,
    input  logic [3:0][W-1:0]    a,
    input  logic [3:0][W-1:0]    b,
    input  logic [W-1:0]         k,
    output logic                 out_valid,
    output logic [3:0][W-1:0]    res,
    output logic                 res_sat,
    output logic                 is_norm,
    output logic                 all_zero,
    output logic [2*W+1:0]       ssum,
    output logic [3:0][W-1:0]    absa,
    output logic [3:0]           nega
);

    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam int RW = ((SW > F) ? SW : F) + 2;

    localparam logic signed [RW-1:0] MAXV = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [RW-1:0] MINV = {{(RW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [RW-1:0] HALF = {{(RW-1){1'b0}}, 1'b1} << (F - 1);
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

    // {clip flag, clipped value}
    function automatic logic [W:0] clip_rw(input logic signed [RW-1:0] v);
        logic [W:0] c;
        if (v > MAXV)
        begin
            c = {1'b1, MAXW};
        end
        else if (v < MINV)
        begin
            c = {1'b1, MINW};
        end
        else
        begin
            c = {1'b0, v[W-1:0]};
        end
        return c;
    endfunction

    // ---------------- stage 1: operand select and multiply
    logic signed [W-1:0]  mx [4][4];
    logic signed [W-1:0]  my [4][4];
    logic signed [PW-1:0] prod_next [4][4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                mx[r][j] = '0;
                my[r][j] = '0;
                case (func)
                    FUNC_PROD:
                    begin
                        mx[r][j] = a[j];
                        my[r][j] = b[r ^ j];
                    end
                    FUNC_SCALE:
                    begin
                        if (j == 0)
                        begin
                            mx[r][j] = a[r];
                            my[r][j] = k;
                        end
                    end
                    FUNC_NORM:
                    begin
                        if (r == 0)
                        begin
                            mx[r][j] = a[j];
                            my[r][j] = a[j];
                        end
                    end
                    default:
                    begin
                    end
                endcase
                prod_next[r][j] = PW'(mx[r][j]) * PW'(my[r][j]);
            end
        end
    end

    logic                 s1_valid_reg;
    logic [FUNC_BITS-1:0] s1_func_reg;
    logic signed [PW-1:0] s1_prod_reg [4][4];
    logic [3:0][W-1:0]    s1_a_reg;
    logic [3:0][W-1:0]    s1_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_func_reg <= func;
            s1_prod_reg <= prod_next;
            s1_a_reg    <= a;
            s1_b_reg    <= b;
        end
    end

    // ---------------- stage 2: signed row sums, add and subtract
    logic signed [SW-1:0] sum_next [4];
    logic signed [W:0]    as_v [4];
    logic [3:0][W-1:0]    as_val_next;
    logic [3:0]           as_sat_next;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sum_next[r] = '0;
            for (int j = 0; j < 4; j++)
            begin
                if (s1_func_reg == FUNC_PROD && HAM_NEG[r*4+j])
                begin
                    sum_next[r] = sum_next[r] - SW'(s1_prod_reg[r][j]);
                end
                else
                begin
                    sum_next[r] = sum_next[r] + SW'(s1_prod_reg[r][j]);
                end
            end
            if (s1_func_reg == FUNC_SUB)
            begin
                as_v[r] = $signed({s1_a_reg[r][W-1], s1_a_reg[r]})
                        - $signed({s1_b_reg[r][W-1], s1_b_reg[r]});
            end
            else
            begin
                as_v[r] = $signed({s1_a_reg[r][W-1], s1_a_reg[r]})
                        + $signed({s1_b_reg[r][W-1], s1_b_reg[r]});
            end
            as_sat_next[r] = as_v[r][W] != as_v[r][W-1];
            if (as_sat_next[r])
            begin
                as_val_next[r] = as_v[r][W] ? MINW : MAXW;
            end
            else
            begin
                as_val_next[r] = as_v[r][W-1:0];
            end
        end
    end

    logic                 s2_valid_reg;
    logic [FUNC_BITS-1:0] s2_func_reg;
    logic signed [SW-1:0] s2_sum_reg [4];
    logic [3:0][W-1:0]    s2_as_reg;
    logic [3:0]           s2_as_sat_reg;
    logic [3:0][W-1:0]    s2_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_func_reg   <= s1_func_reg;
            s2_sum_reg    <= sum_next;
            s2_as_reg     <= as_val_next;
            s2_as_sat_reg <= as_sat_next;
            s2_a_reg      <= s1_a_reg;
        end
    end

    // ---------------- stage 3: round to nearest, clip, select
    logic signed [RW-1:0] rnd [4];
    logic [W:0]           rc [4];
    logic [3:0][W-1:0]    res_next;
    logic                 sat_next;
    logic [3:0][W-1:0]    absa_next;
    logic [3:0]           nega_next;
    logic                 zero_next;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            rnd[r] = (RW'(s2_sum_reg[r]) + HALF) >>> F;
            rc[r]  = clip_rw(rnd[r]);
            nega_next[r] = s2_a_reg[r][W-1];
            absa_next[r] = nega_next[r] ? (W'(0) - s2_a_reg[r]) : s2_a_reg[r];
        end
        zero_next = (s2_a_reg == '0);
        case (s2_func_reg)
            FUNC_PROD, FUNC_SCALE:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    res_next[r] = rc[r][W-1:0];
                end
                sat_next = rc[0][W] | rc[1][W] | rc[2][W] | rc[3][W];
            end
            FUNC_ADD, FUNC_SUB:
            begin
                res_next = s2_as_reg;
                sat_next = |s2_as_sat_reg;
            end
            default:
            begin
                res_next = '0;
                sat_next = 1'b0;
            end
        endcase
    end

    logic                 s3_valid_reg;
    logic [3:0][W-1:0]    s3_res_reg;
    logic                 s3_sat_reg;
    logic                 s3_norm_reg;
    logic                 s3_zero_reg;
    logic [SW-1:0]        s3_ssum_reg;
    logic [3:0][W-1:0]    s3_absa_reg;
    logic [3:0]           s3_nega_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_res_reg  <= res_next;
            s3_sat_reg  <= sat_next;
            s3_norm_reg <= (s2_func_reg == FUNC_NORM);
            s3_zero_reg <= zero_next;
            s3_ssum_reg <= s2_sum_reg[0];
            s3_absa_reg <= absa_next;
            s3_nega_reg <= nega_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign res       = s3_res_reg;
    assign res_sat   = s3_sat_reg;
    assign is_norm   = s3_norm_reg;
    assign all_zero  = s3_zero_reg;
    assign ssum      = s3_ssum_reg;
    assign absa      = s3_absa_reg;
    assign nega      = s3_nega_reg;

endmodule

// ===== rtl/qau_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Carries a sideband word alongside. Depends on qau_pkg.
module qau_sqrt
    import qau_pkg::*;
#(
    parameter int N      = 25,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*N-1:0]    radicand,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [N-1:0]      root,
    output logic [SIDE_W-1:0] side_out
);

    logic [N-1:0]      vld_reg;
    logic [N+1:0]      rem_reg  [N];
    logic [N-1:0]      root_reg [N];
    logic [2*N-1:0]    rad_reg  [N];
    logic [SIDE_W-1:0] side_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic              v_in;
        logic [N+1:0]      rem_in;
        logic [N-1:0]      root_in;
        logic [2*N-1:0]    rad_in;
        logic [SIDE_W-1:0] sd_in;
        logic [N+3:0]      t_rem;
        logic [N+3:0]      t_sub;
        logic              ge;
        logic [N+1:0]      rem_next;
        logic [N-1:0]      root_next;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
            assign sd_in   = side_in;
        end
        else
        begin : g_next
            assign v_in    = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign sd_in   = side_reg[i-1];
        end

        // bring down the next two radicand bits, try (4*root + 1)
        assign t_rem     = {rem_in, rad_in[2*(N-1-i) +: 2]};
        assign t_sub     = (N+4)'({root_in, 2'b01});
        assign ge        = t_rem >= t_sub;
        assign rem_next  = ge ? (N+2)'(t_rem - t_sub) : t_rem[N+1:0];
        assign root_next = {root_in[N-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                rad_reg[i]  <= rad_in;
                side_reg[i] <= sd_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

// ===== rtl/qau_div.sv =====
// Four-lane pipelined restoring divider for normalize: (|a| * 2^F + mag/2) / mag.
// One setup stage, then one quotient bit per stage. Depends on qau_pkg.
module qau_div
    import qau_pkg::*;
#(
    parameter int W      = 24,
    parameter int F      = 20,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W:0]        mag,
    input  logic [3:0][W-1:0] absa,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [3:0][F:0]   quot,
    output logic [SIDE_W-1:0] side_out
);

    localparam int DW = W + F + 1;
    localparam int QS = F + 1;

    // ---------------- setup: rounded dividend, top part is the first remainder
    logic [DW-1:0]     dvd [4];
    logic [3:0][W:0]   rem0_next;
    logic [3:0][F:0]   low_next;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            dvd[l]       = (DW'(absa[l]) << F) + DW'(mag >> 1);
            rem0_next[l] = (W+1)'(dvd[l][DW-1:F+1]);
            low_next[l]  = dvd[l][F:0];
        end
    end

    logic              su_valid_reg;
    logic [3:0][W:0]   su_rem_reg;
    logic [3:0][F:0]   su_low_reg;
    logic [W:0]        su_mag_reg;
    logic [SIDE_W-1:0] su_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            su_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            su_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            su_rem_reg  <= rem0_next;
            su_low_reg  <= low_next;
            su_mag_reg  <= mag;
            su_side_reg <= side_in;
        end
    end

    // ---------------- quotient bit stages
    logic [QS-1:0]     vld_reg;
    logic [3:0][W:0]   rem_reg  [QS];
    logic [3:0][F:0]   low_reg  [QS];
    logic [3:0][F:0]   q_reg    [QS];
    logic [W:0]        mag_reg  [QS];
    logic [SIDE_W-1:0] side_reg [QS];

    for (genvar i = 0; i < QS; i++)
    begin : g_step
        logic              v_in;
        logic [3:0][W:0]   rem_in;
        logic [3:0][F:0]   low_in;
        logic [3:0][F:0]   q_in;
        logic [W:0]        mag_in;
        logic [SIDE_W-1:0] sd_in;
        logic [3:0][W:0]   rem_next;
        logic [3:0][F:0]   q_next;

        if (i == 0)
        begin : g_first
            assign v_in   = su_valid_reg;
            assign rem_in = su_rem_reg;
            assign low_in = su_low_reg;
            assign q_in   = '0;
            assign mag_in = su_mag_reg;
            assign sd_in  = su_side_reg;
        end
        else
        begin : g_next
            assign v_in   = vld_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign mag_in = mag_reg[i-1];
            assign sd_in  = side_reg[i-1];
        end

        always_comb
        begin
            for (int l = 0; l < 4; l++)
            begin
                if ({rem_in[l], low_in[l][F-i]} >= (W+2)'(mag_in))
                begin
                    rem_next[l] = (W+1)'({rem_in[l], low_in[l][F-i]} - (W+2)'(mag_in));
                    q_next[l]   = {q_in[l][F-1:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = {rem_in[l][W-1:0], low_in[l][F-i]};
                    q_next[l]   = {q_in[l][F-1:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                low_reg[i]  <= low_in;
                q_reg[i]    <= q_next;
                mag_reg[i]  <= mag_in;
                side_reg[i] <= sd_in;
            end
        end
    end

    assign out_valid = vld_reg[QS-1];
    assign quot      = q_reg[QS-1];
    assign side_out  = side_reg[QS-1];

endmodule

// ===== tb/sv/tb_quaternion_arithmetic_unit.sv =====
// Testbench for quaternion_arithmetic_unit: random and corner-case quaternion ops,
// results predicted in-bench and checked in order. Depends on qau_pkg and the RTL.
`timescale 1ns / 1ps

module tb_quaternion_arithmetic_unit;
    import qau_pkg::*;

    localparam int FB = 20;
    localparam int WB = 24;
    localparam longint WMAX = (64'sd1 <<< (WB - 1)) - 1;
    localparam longint WMIN = -WMAX - 1;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 1350;
    localparam int LATENCY = WB + FB + 8;

    typedef logic signed [WB-1:0] word_t;

    typedef struct packed {
        logic [FUNC_BITS-1:0] op;
        word_t [3:0] a;
        word_t [3:0] b;
        word_t k;
    } op_word_t;

    typedef struct packed {
        word_t [3:0] q;
        logic sat;
        logic zmag;
    } quat_result_t;

    logic clk, rst_n;
    logic in_ready, out_valid;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic [FUNC_BITS-1:0] func = '0;
    word_t a_w = '0, a_x = '0, a_y = '0, a_z = '0;
    word_t b_w = '0, b_x = '0, b_y = '0, b_z = '0, scale_factor = '0;
    word_t r_w, r_x, r_y, r_z;
    logic saturated, zero_magnitude;

    op_word_t pending_ops[$];
    quat_result_t expected_quats[$];
    int errors = 0;
    bit stim_done = 0;
    bit quiet = 0;
    longint cycles = 0;
    int in_gap = 0, out_gap = 0;
    op_word_t w_drive;
    logic in_ready_seen = 1'b0;

    quaternion_arithmetic_unit #(.FRAC_BITS(FB), .WORD_BITS(WB)) uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z), .scale_factor(scale_factor),
        .out_valid(out_valid), .out_ready(out_ready),
        .r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z),
        .saturated(saturated), .zero_magnitude(zero_magnitude)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic longint clip_word(input longint v, inout logic sat);
        if (v > WMAX)
        begin
            sat = 1;
            return WMAX;
        end
        if (v < WMIN)
        begin
            sat = 1;
            return WMIN;
        end
        return v;
    endfunction

    // round to nearest, ties up; 128-bit keeps the four-term sums exact
    function automatic longint round_frac(input logic signed [127:0] s);
        logic signed [127:0] t;
        t = (s + (128'sd1 <<< (FB - 1))) >>> FB;
        return longint'(t);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [64:0] v);
        logic [64:0] lo, hi, mid;
        lo = 0;
        hi = 65'h1_0000_0000;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo[63:0];
    endfunction

    function automatic quat_result_t quat_compute(input op_word_t w);
        quat_result_t res;
        longint a[4], b[4], k, v;
        logic signed [127:0] s;
        logic [64:0] sumsq;
        logic [63:0] mag, num, quo;
        logic sat;
        // row r, term j uses a[j]*b[r^j]; HAM_NEG marks subtracted terms
        res = '0;
        sat = 0;
        for (int i = 0; i < 4; i++)
        begin
            a[i] = longint'(w.a[3-i]);
            b[i] = longint'(w.b[3-i]);
        end
        k = longint'(w.k);
        case (w.op)
            FUNC_PROD:
                for (int r = 0; r < 4; r++)
                begin
                    s = 0;
                    for (int j = 0; j < 4; j++)
                        if (HAM_NEG[r*4+j]) s -= 128'(a[j] * b[r ^ j]);
                        else s += 128'(a[j] * b[r ^ j]);
                    res.q[3-r] = word_t'(clip_word(round_frac(s), sat));
                end
            FUNC_ADD:
                for (int i = 0; i < 4; i++)
                    res.q[3-i] = word_t'(clip_word(a[i] + b[i], sat));
            FUNC_SUB:
                for (int i = 0; i < 4; i++)
                    res.q[3-i] = word_t'(clip_word(a[i] - b[i], sat));
            FUNC_SCALE:
                for (int i = 0; i < 4; i++)
                    res.q[3-i] = word_t'(clip_word(round_frac(128'(a[i] * k)), sat));
            FUNC_NORM:
            begin
                sumsq = 0;
                for (int i = 0; i < 4; i++) sumsq += 65'(a[i] * a[i]);
                if (sumsq == 0) res.zmag = 1;
                else
                begin
                    mag = int_sqrt(sumsq);
                    for (int i = 0; i < 4; i++)
                    begin
                        num = 64'(a[i] < 0 ? -a[i] : a[i]) << FB;
                        quo = (num + (mag >> 1)) / mag;
                        v = longint'(quo);
                        res.q[3-i] = word_t'(clip_word(a[i] < 0 ? -v : v, sat));
                    end
                end
            end
            default: ;
        endcase
        res.sat = sat;
        return res;
    endfunction

    function automatic word_t rand_word(input int mode);
        case (mode)
            0: return word_t'($urandom);
            1: return word_t'(word_t'($urandom_range(0, 2047)) - 1024);
            2: return word_t'(($urandom_range(0, 1) ? WMAX : WMIN) + $urandom_range(0, 3)
                      - ($urandom_range(0, 1) ? 3 : 0));
            default: return word_t'(word_t'($urandom_range(0, 1) ? 24'sh100000 : -24'sh100000)
                            + word_t'($urandom_range(0, 255)) - 128);
        endcase
    endfunction

    function automatic op_word_t build_op(input logic [FUNC_BITS-1:0] op, input word_t fill_a,
                                          input word_t fill_b, input word_t k);
        op_word_t w;
        w.op = op;
        for (int i = 0; i < 4; i++)
        begin
            w.a[i] = fill_a;
            w.b[i] = fill_b;
        end
        w.k = k;
        return w;
    endfunction

    initial
    begin
        op_word_t w;
        int mode;
        for (int op = 0; op < 8; op++)
        begin
            pending_ops.push_back(build_op(FUNC_BITS'(op), word_t'(WMAX), word_t'(WMAX),
                                           word_t'(WMAX)));
            pending_ops.push_back(build_op(FUNC_BITS'(op), word_t'(WMIN), word_t'(WMIN),
                                           word_t'(WMIN)));
        end
        // zero-length normalize
        pending_ops.push_back(build_op(FUNC_NORM, word_t'(0), word_t'(5), word_t'(5)));
        // tiny magnitude
        pending_ops.push_back(build_op(FUNC_NORM, word_t'(1), word_t'(0), word_t'(0)));
        pending_ops.push_back(build_op(FUNC_PROD, 24'sh100000, word_t'(WMIN), 24'sh100000));
        // rounding tie
        pending_ops.push_back(build_op(FUNC_SCALE, word_t'(-1), word_t'(0), 24'sh080000));
        w = build_op(FUNC_NORM, word_t'(0), word_t'(0), word_t'(0));
        w.a[3] = -24'sd3;
        pending_ops.push_back(w);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            mode = $urandom_range(0, 3);
            w.op = ($urandom_range(0, 19) == 0) ? FUNC_BITS'($urandom_range(5, 7))
                                                : FUNC_BITS'($urandom_range(0, 4));
            for (int i = 0; i < 4; i++)
            begin
                w.a[i] = rand_word(mode);
                w.b[i] = rand_word($urandom_range(0, 3));
            end
            w.k = rand_word($urandom_range(0, 3));
            if (w.op == FUNC_NORM && $urandom_range(0, 15) == 0) w.a = '0;
            pending_ops.push_back(w);
        end
        stim_done = 1;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            out_ready <= 0;
        end
        else
        begin
            if (!in_valid || in_ready_seen)
            begin
                if (in_gap > 0) in_gap <= in_gap - 1;
                if (in_gap == 0 && pending_ops.size() > 0 &&
                    (quiet || $urandom_range(0, 5) != 0))
                begin
                    w_drive = pending_ops.pop_front();
                    {func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale_factor} <= w_drive;
                    in_valid <= 1;
                    expected_quats.push_back(quat_compute(w_drive));
                end
                else
                begin
                    in_valid <= 0;
                    if (in_gap == 0 && !quiet && pending_ops.size() > 0)
                        in_gap <= $urandom_range(0, 2);
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_gap <= $urandom_range(0, 2);
                out_ready <= 0;
            end
            else out_ready <= 1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        quat_result_t got, exp_q;
        in_ready_seen <= in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{q: {r_w, r_x, r_y, r_z}, sat: saturated, zmag: zero_magnitude};
            if (expected_quats.size() == 0)
            begin
                $error("result word with none expected");
                errors++;
            end
            else
            begin
                exp_q = expected_quats.pop_front();
                if (got.q[3] !== exp_q.q[3])
                begin
                    $error("r_w expected %0d got %0d", exp_q.q[3], got.q[3]);
                    errors++;
                end
                if (got.q[2] !== exp_q.q[2])
                begin
                    $error("r_x expected %0d got %0d", exp_q.q[2], got.q[2]);
                    errors++;
                end
                if (got.q[1] !== exp_q.q[1])
                begin
                    $error("r_y expected %0d got %0d", exp_q.q[1], got.q[1]);
                    errors++;
                end
                if (got.q[0] !== exp_q.q[0])
                begin
                    $error("r_z expected %0d got %0d", exp_q.q[0], got.q[0]);
                    errors++;
                end
                if (got.sat !== exp_q.sat)
                begin
                    $error("saturated expected %0b got %0b", exp_q.sat, got.sat);
                    errors++;
                end
                if (got.zmag !== exp_q.zmag)
                begin
                    $error("zero_magnitude expected %0b got %0b", exp_q.zmag, got.zmag);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        wait (stim_done);
        while (pending_ops.size() > 300) @(posedge clk);
        quiet = 1;  // last part runs without idling
        while (pending_ops.size() > 0 || in_valid) @(posedge clk);
        while (expected_quats.size() > 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && expected_quats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/qau_pkg.sv
rtl/qau_front.sv
rtl/qau_sqrt.sv
rtl/qau_div.sv
rtl/quaternion_arithmetic_unit.sv
tb/sv/tb_quaternion_arithmetic_unit.sv
